[rtl/a51_pkg.sv]
// Shared constants and controller-to-datapath command type for the A5/1 keystream generator.
`default_nettype none
package a51_pkg;

	localparam int unsigned KEY_W   = 64;
	localparam int unsigned FRAME_W = 22;
	localparam int unsigned LOAD_W  = KEY_W + FRAME_W;

	localparam int unsigned R1_W = 19;
	localparam int unsigned R2_W = 22;
	localparam int unsigned R3_W = 23;

	localparam logic [R1_W-1:0] TAPS_ONE   = 19'h72000;
	localparam logic [R2_W-1:0] TAPS_TWO   = 22'h300000;
	localparam logic [R3_W-1:0] TAPS_THREE = 23'h700080;

	localparam int unsigned CLK_ONE   = 8;
	localparam int unsigned CLK_TWO   = 10;
	localparam int unsigned CLK_THREE = 10;

	localparam logic [6:0] LOAD_LAST = 7'd85;
	localparam logic [6:0] MIX_LAST  = 7'd99;
	localparam logic [3:0] BYTE_LAST = 4'd14;
	localparam logic [2:0] BIT_LAST  = 3'd7;
	localparam logic [2:0] SHORT_LAST = 3'd1;

	typedef struct packed {
		logic start;
		logic step_all;
		logic step_maj;
		logic short_byte;
	} a51_cmd_t;

endpackage
`default_nettype wire

[rtl/a51_datapath.sv]
// A5/1 datapath: key register, load shifter, three LFSRs and byte assembler.
`default_nettype none
module a51_datapath import a51_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 key_we,
	input  wire logic [KEY_W-1:0]     session_key,
	input  wire logic [FRAME_W-1:0]   frame_number,
	input  wire a51_cmd_t             cmd,
	output logic      [7:0]           new_byte
);

	logic [KEY_W-1:0]  key_q;
	logic [LOAD_W-1:0] load_q;
	logic [R1_W-1:0]   r1_q;
	logic [R2_W-1:0]   r2_q;
	logic [R3_W-1:0]   r3_q;
	logic [7:0]        byte_q;

	logic [R1_W-1:0] r1_sh;
	logic [R2_W-1:0] r2_sh;
	logic [R3_W-1:0] r3_sh;
	logic [R1_W-1:0] r1_nx;
	logic [R2_W-1:0] r2_nx;
	logic [R3_W-1:0] r3_nx;
	logic            in_bit;
	logic            a, b, c, maj;
	logic            nb;

	assign r1_sh = {r1_q[R1_W-2:0], ^(r1_q & TAPS_ONE)};
	assign r2_sh = {r2_q[R2_W-2:0], ^(r2_q & TAPS_TWO)};
	assign r3_sh = {r3_q[R3_W-2:0], ^(r3_q & TAPS_THREE)};

	assign in_bit = load_q[0];
	assign a   = r1_q[CLK_ONE];
	assign b   = r2_q[CLK_TWO];
	assign c   = r3_q[CLK_THREE];
	assign maj = (a & b) | (a & c) | (b & c);

	always_comb begin
		r1_nx = r1_q;
		r2_nx = r2_q;
		r3_nx = r3_q;
		if (cmd.step_all) begin
			r1_nx = {r1_sh[R1_W-1:1], r1_sh[0] ^ in_bit};
			r2_nx = {r2_sh[R2_W-1:1], r2_sh[0] ^ in_bit};
			r3_nx = {r3_sh[R3_W-1:1], r3_sh[0] ^ in_bit};
		end else if (cmd.step_maj) begin
			if (a == maj) r1_nx = r1_sh;
			if (b == maj) r2_nx = r2_sh;
			if (c == maj) r3_nx = r3_sh;
		end
	end

	assign nb = r1_nx[R1_W-1] ^ r2_nx[R2_W-1] ^ r3_nx[R3_W-1];
	assign new_byte = cmd.short_byte ? {byte_q[0], nb, 6'b0} : {byte_q[6:0], nb};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			r1_q  <= '0;
			r2_q  <= '0;
			r3_q  <= '0;
		end else begin
			if (key_we) key_q <= session_key;
			if (cmd.start) begin
				r1_q <= '0;
				r2_q <= '0;
				r3_q <= '0;
			end else begin
				r1_q <= r1_nx;
				r2_q <= r2_nx;
				r3_q <= r3_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			load_q <= {frame_number, key_q};
		end else if (cmd.step_all) begin
			load_q <= {1'b0, load_q[LOAD_W-1:1]};
		end
		if (cmd.step_maj) byte_q <= {byte_q[6:0], nb};
	end

endmodule
`default_nettype wire

[rtl/a51_ctrl.sv]
// A5/1 sequencer: load, mixing and output phases with byte and direction counters.
`default_nettype none
module a51_ctrl import a51_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       out_free,
	output a51_cmd_t        cmd,
	output logic            push,
	output logic            push_dir,
	output logic [3:0]      push_idx,
	output logic            push_last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_MIX  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0] state_q;
	logic [6:0] cnt_q;
	logic [2:0] bit_q;
	logic [3:0] idx_q;
	logic       dir_q;
	logic       byte_end;
	logic       go;

	assign in_stall  = (state_q != ST_IDLE);
	assign byte_end  = (bit_q == BIT_LAST) || ((idx_q == BYTE_LAST) && (bit_q == SHORT_LAST));
	assign go        = !byte_end || out_free;
	assign push_dir  = dir_q;
	assign push_idx  = idx_q;
	assign push_last = dir_q && (idx_q == BYTE_LAST);

	always_comb begin
		cmd  = '0;
		push = 1'b0;
		case (state_q)
			ST_IDLE: cmd.start = in_valid;
			ST_LOAD: cmd.step_all = 1'b1;
			ST_MIX:  cmd.step_maj = 1'b1;
			ST_OUT: begin
				cmd.step_maj   = go;
				cmd.short_byte = (idx_q == BYTE_LAST);
				push           = go && byte_end;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			bit_q   <= '0;
			idx_q   <= '0;
			dir_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_LOAD;
						cnt_q   <= '0;
					end
				end
				ST_LOAD: begin
					if (cnt_q == LOAD_LAST) begin
						state_q <= ST_MIX;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_MIX: begin
					if (cnt_q == MIX_LAST) begin
						state_q <= ST_OUT;
						bit_q   <= '0;
						idx_q   <= '0;
						dir_q   <= 1'b0;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_OUT: begin
					if (go) begin
						if (byte_end) begin
							bit_q <= '0;
							if (idx_q == BYTE_LAST) begin
								idx_q <= '0;
								if (dir_q) state_q <= ST_IDLE;
								dir_q <= 1'b1;
							end else begin
								idx_q <= idx_q + 4'd1;
							end
						end else begin
							bit_q <= bit_q + 3'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/a51_keystream_generator_unit.sv]
// Top level of the A5/1 keystream generator: sequencer, datapath and output register.
//
//   channel | signals                                              | dir
//   cfg     | key_we, session_key[63:0]                            | in
//   in      | in_valid, in_stall, frame_number[21:0]               | in
//   out     | out_valid, out_stall, direction, byte_index[3:0],    | out
//           | keystream_byte[7:0], last_of_frame                   |
//
// A frame is 1 accept, 86 load steps, 100 mixing steps and 228 output steps,
// one LFSR step per cycle while the output register is not stalled.
// 30 output transactions per frame; a stalled output register halts the LFSRs
// on the step that would complete the next byte.
// Asynchronous active-low reset clears key, LFSRs and control.
`default_nettype none
module a51_keystream_generator_unit import a51_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               key_we,
	input  wire logic [KEY_W-1:0]   session_key,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [FRAME_W-1:0] frame_number,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    direction,
	output logic [3:0]              byte_index,
	output logic [7:0]              keystream_byte,
	output logic                    last_of_frame
);

	a51_cmd_t   cmd;
	logic       push;
	logic       push_dir;
	logic [3:0] push_idx;
	logic       push_last;
	logic [7:0] new_byte;
	logic       out_free;

	logic       valid_q;
	logic       dir_q;
	logic [3:0] idx_q;
	logic [7:0] byte_q;
	logic       last_q;

	assign out_free = !valid_q || !out_stall;

	a51_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_free  (out_free),
		.cmd       (cmd),
		.push      (push),
		.push_dir  (push_dir),
		.push_idx  (push_idx),
		.push_last (push_last)
	);

	a51_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.key_we       (key_we),
		.session_key  (session_key),
		.frame_number (frame_number),
		.cmd          (cmd),
		.new_byte     (new_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			dir_q  <= push_dir;
			idx_q  <= push_idx;
			byte_q <= new_byte;
			last_q <= push_last;
		end
	end

	assign out_valid      = valid_q;
	assign direction      = dir_q;
	assign byte_index     = idx_q;
	assign keystream_byte = byte_q;
	assign last_of_frame  = last_q;

endmodule
`default_nettype wire

[verif/tb_top.sv]
// Self-checking A5/1 generator testbench: directed, random, backpressure and sender-pause tests.
`timescale 1ns / 1ps
module tb_top;
	import a51_pkg::*;

	typedef struct packed {
		logic       dir;
		logic [3:0] idx;
		logic [7:0] ks;
		logic       last;
	} ks_txn_t;

	localparam logic [22:0] R1_MASK = 23'h07FFFF;
	localparam logic [22:0] R2_MASK = 23'h3FFFFF;
	localparam logic [22:0] R3_MASK = 23'h7FFFFF;
	localparam logic [22:0] R1_FB   = 23'h072000;
	localparam logic [22:0] R2_FB   = 23'h300000;
	localparam logic [22:0] R3_FB   = 23'h700080;

	logic               clk;
	logic               arst_n;
	logic               key_we;
	logic [KEY_W-1:0]   session_key;
	logic               in_valid;
	logic               in_stall;
	logic [FRAME_W-1:0] frame_number;
	logic               out_valid;
	logic               out_stall;
	logic               direction;
	logic [3:0]         byte_index;
	logic [7:0]         keystream_byte;
	logic               last_of_frame;

	ks_txn_t     ks_expected[$];
	logic [63:0] key_shadow;
	logic [22:0] lfsr_a, lfsr_b, lfsr_c;
	int          err_count;
	bit          gaps_on;
	bit          stall_on;
	int          hold_cycles;
	int          stall_left;

	a51_keystream_generator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.key_we        (key_we),
		.session_key   (session_key),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.frame_number  (frame_number),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.direction     (direction),
		.byte_index    (byte_index),
		.keystream_byte(keystream_byte),
		.last_of_frame (last_of_frame)
	);

	always #5 clk = ~clk;

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [22:0] lfsr_shift(logic [22:0] r, logic [22:0] mask,
			logic [22:0] taps);
		return ((r << 1) & mask) | {22'd0, ^(r & taps)};
	endfunction

	function automatic void clock_all(logic in_bit);
		lfsr_a = lfsr_shift(lfsr_a, R1_MASK, R1_FB) ^ {22'd0, in_bit};
		lfsr_b = lfsr_shift(lfsr_b, R2_MASK, R2_FB) ^ {22'd0, in_bit};
		lfsr_c = lfsr_shift(lfsr_c, R3_MASK, R3_FB) ^ {22'd0, in_bit};
	endfunction

	function automatic void clock_majority();
		logic a, b, c, maj;
		a = lfsr_a[8];
		b = lfsr_b[10];
		c = lfsr_c[10];
		maj = (a & b) | (a & c) | (b & c);
		if (a == maj)
			lfsr_a = lfsr_shift(lfsr_a, R1_MASK, R1_FB);
		if (b == maj)
			lfsr_b = lfsr_shift(lfsr_b, R2_MASK, R2_FB);
		if (c == maj)
			lfsr_c = lfsr_shift(lfsr_c, R3_MASK, R3_FB);
	endfunction

	// Queues the 30 keystream bytes of one frame under the current key.
	function automatic void predict_keystream(logic [21:0] fn);
		logic [7:0] bytes[15];
		ks_txn_t    t;
		lfsr_a = '0;
		lfsr_b = '0;
		lfsr_c = '0;
		for (int i = 0; i < 64; i++)
			clock_all(key_shadow[i]);
		for (int i = 0; i < 22; i++)
			clock_all(fn[i]);
		for (int i = 0; i < 100; i++)
			clock_majority();
		for (int d = 0; d < 2; d++) begin
			for (int k = 0; k < 15; k++)
				bytes[k] = '0;
			for (int i = 0; i < 114; i++) begin
				clock_majority();
				bytes[i >> 3][7 - (i & 7)] = lfsr_a[18] ^ lfsr_b[21] ^ lfsr_c[22];
			end
			for (int k = 0; k < 15; k++) begin
				t.dir  = d[0];
				t.idx  = k[3:0];
				t.ks   = bytes[k];
				t.last = (d == 1 && k == 14);
				ks_expected.push_back(t);
			end
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_frame(input logic [21:0] fn);
		int gap;
		gap = gaps_on ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		frame_number <= fn;
		do
			@(posedge clk);
		while (in_stall);
		predict_keystream(fn);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (ks_expected.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_key(input logic [63:0] k);
		drain();
		key_we      <= 1'b1;
		session_key <= k;
		key_shadow  = k;
		@(negedge clk);
		key_we <= 1'b0;
	endtask

	task automatic test_directed();
		// first frames run on the reset key of zero
		send_frame(22'h000000);
		send_frame(22'h3FFFFF);
		send_frame(22'h155555);
		send_frame(22'h2AAAAA);
		write_key(64'hFFFF_FFFF_FFFF_FFFF);
		send_frame(22'h000000);
		send_frame(22'h3FFFFF);
		write_key(64'h0000_0000_0000_0001);
		send_frame(22'h000001);
		write_key(64'h8000_0000_0000_0000);
		send_frame(22'h200000);
		write_key(64'hEFCD_AB89_6745_2312);
		// same frame twice: no carry-over between frames
		send_frame(22'h000134);
		send_frame(22'h000134);
		write_key(64'hAAAA_AAAA_AAAA_AAAA);
		send_frame(22'h155555);
		write_key(64'h5555_5555_5555_5555);
		send_frame(22'h2AAAAA);
		write_key(64'h0000_0000_0000_0000);
		send_frame(22'h0F0F0F);
	endtask

	task automatic test_random();
		for (int p = 0; p < 4; p++) begin
			write_key({$urandom, $urandom});
			gaps_on  = (p != 2);
			stall_on = (p != 2);
			for (int n = 0; n < 20; n++)
				send_frame(22'($urandom_range(0, 22'h3FFFFF)));
		end
		gaps_on  = 1'b1;
		stall_on = 1'b1;
	endtask

	task automatic test_backpressure();
		drain();
		gaps_on = 1'b0;
		@(posedge clk);
		hold_cycles = 1500;
		@(negedge clk);
		for (int n = 0; n < 4; n++)
			send_frame(22'($urandom_range(0, 22'h3FFFFF)));
		gaps_on = 1'b1;
		drain();
	endtask

	task automatic test_sender_pause();
		for (int n = 0; n < 3; n++)
			send_frame(22'($urandom_range(0, 22'h3FFFFF)));
		drain();
		for (int n = 0; n < 3; n++)
			send_frame(22'($urandom_range(0, 22'h3FFFFF)));
	endtask

	// receiver stall generator
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall   <= 1'b1;
				hold_cycles = hold_cycles - 1;
			end else if (stall_left > 0) begin
				out_stall  <= 1'b1;
				stall_left = stall_left - 1;
			end else if (stall_on && $urandom_range(0, 3) == 0) begin
				stall_left = idle_len();
				out_stall  <= (stall_left > 0);
				if (stall_left > 0)
					stall_left = stall_left - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		ks_txn_t exp_t;
		if (arst_n && out_valid && !out_stall) begin
			if (ks_expected.size() == 0) begin
				$error("unexpected transaction: dir=%0d idx=%0d byte=%02h last=%0d",
					direction, byte_index, keystream_byte, last_of_frame);
				err_count++;
			end else begin
				exp_t = ks_expected.pop_front();
				if (direction !== exp_t.dir) begin
					$error("direction: expected %0d, got %0d", exp_t.dir, direction);
					err_count++;
				end
				if (byte_index !== exp_t.idx) begin
					$error("byte_index: expected %0d, got %0d", exp_t.idx, byte_index);
					err_count++;
				end
				if (keystream_byte !== exp_t.ks) begin
					$error("keystream_byte: expected %02h, got %02h", exp_t.ks,
						keystream_byte);
					err_count++;
				end
				if (last_of_frame !== exp_t.last) begin
					$error("last_of_frame: expected %0d, got %0d", exp_t.last,
						last_of_frame);
					err_count++;
				end
			end
		end
	end

	initial begin
		#15ms;
		$display("FAILURE");
		$finish;
	end

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		key_we       = 1'b0;
		session_key  = '0;
		in_valid     = 1'b0;
		frame_number = '0;
		key_shadow   = '0;
		err_count    = 0;
		gaps_on      = 1'b1;
		stall_on     = 1'b1;
		hold_cycles  = 0;
		stall_left   = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random();
		test_backpressure();
		test_sender_pause();

		drain();
		repeat (450) @(negedge clk);
		if (err_count == 0 && ks_expected.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
